### hw/rtl/tes_pkg.sv
// Shared constants for the tetrahedron element stiffness core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tes_pkg;
  localparam int NUM_VERT   = 4;
  localparam int NUM_AXES   = 3;
  localparam int NUM_COORDS = NUM_VERT * NUM_AXES;
  localparam int LANES      = 4;
  localparam int ROW_W      = 2;
  localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
  localparam logic [ROW_W-1:0] ROW_LAST  = 2'd3;
  localparam int DET_SHIFT  = 24;   // Q48.48 determinant -> Q24.24
  localparam int DOT_SHIFT  = 11;   // 8 * 2^24 / 2^16 scale of ke
  localparam int USER_W     = 4;
endpackage
`default_nettype wire

### hw/rtl/tet_element_stiffness_core.sv
// Top level: linear tetrahedron element stiffness, one matrix row per output request.
// Depends on tes_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Takes four vertices (signed Q16.16) per input request and returns four output
// requests, rows 0..3 of ke[a][b] = 8*detJ*(grad Na . grad Nb) in signed Q24.24,
// with detJ, a degenerate flag (exact zero determinant, entries zero) and a
// saturation flag. The four rows of an element share a single row pipeline that
// takes one row per cycle while the output is not stalled. A row passes through the
// Jacobian, cofactor, determinant and dot-product stages, one divider set-up stage,
// then one restoring quotient bit per stage in four parallel divider lanes, then the
// output register. Back-pressure stalls the whole pipeline; the input register takes
// a new element only while it is empty or issuing its last row.
module tet_element_stiffness_core
  import tes_pkg::*;
#(
  parameter int COORD_WIDTH  = 32,
  parameter int RESULT_WIDTH = 48
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // x0 y0 z0 x1 y1 z1 x2 y2 z2 x3 y3 z3, zero padded to bytes
  input  wire logic [((NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // k_col0 k_col1 k_col2 k_col3 jacobian_det, zero padded to bytes
  output logic [((5*RESULT_WIDTH+7)/8)*8-1:0] out_tdata,
  // row_index[1:0] degenerate saturated
  output logic [USER_W-1:0]        out_tuser,
  output logic                     out_tlast
);
  localparam int RW   = RESULT_WIDTH;
  localparam int JW   = COORD_WIDTH + 1;
  localparam int CFW  = 2 * JW + 1;
  localparam int LO1  = CFW / 2;
  localparam int HI1  = CFW - LO1;
  localparam int DW   = JW + CFW + 2;
  localparam int GW   = CFW + 2;
  localparam int LO2  = GW / 2;
  localparam int HI2  = GW - LO2;
  localparam int PW   = 2 * GW;
  localparam int NW   = PW + 1 + DOT_SHIFT;
  localparam int CMPW = (NW > DW + RW) ? NW : DW + RW;
  localparam int DETX = (DW > RW) ? DW : RW + 1;
  localparam int OUTW = ((5 * RW + 7) / 8) * 8;

  localparam logic [RW-1:0] KMAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic [RW-1:0] KMIN = {1'b1, {(RW-1){1'b0}}};

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             degen;
    logic             dsat;
    logic [RW-1:0]    detv;
    logic [DW-1:0]    dabs;
  } meta_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [RW-1:0] q;
    logic [RW-1:0] nlo;
    logic          neg;
    logic          ov;
  } lane_t;

  logic en;
  logic issue;
  logic accept;
  logic out_valid_r;

  assign en     = !out_valid_r || out_tready;

  // input holding register and row counter
  logic                          hold_v_r;
  logic [ROW_W-1:0]              row_r;
  logic signed [COORD_WIDTH-1:0] p_r [NUM_VERT][NUM_AXES];

  assign issue     = hold_v_r && en;
  assign in_tready = !hold_v_r || (en && row_r == ROW_LAST);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      row_r    <= ROW_FIRST;
    end else begin
      if (issue) begin
        row_r <= row_r + 1'b1;
        if (row_r == ROW_LAST) hold_v_r <= 1'b0;
      end
      if (accept) hold_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int a = 0; a < NUM_VERT; a++)
        for (int i = 0; i < NUM_AXES; i++)
          p_r[a][i] <= in_tdata[(a*NUM_AXES+i)*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  // front stages 1..7
  logic [7:1]        vld_r;
  logic [ROW_W-1:0]  rowp_r [1:7];

  logic signed [JW-1:0]     jac1_r [3][3];
  logic signed [JW-1:0]     jac1_nxt [3][3];
  logic signed [2*JW-1:0]   m2_r [3][3][2];
  logic signed [2*JW-1:0]   m2_nxt [3][3][2];
  logic signed [JW-1:0]     j0_2_r [3];
  logic signed [JW-1:0]     j0_3_r [3];
  logic signed [CFW-1:0]    cof3_r [3][3];
  logic signed [CFW-1:0]    cof3_nxt [3][3];
  logic signed [JW+LO1:0]   pl4_r [3];
  logic signed [JW+LO1:0]   pl4_nxt [3];
  logic signed [JW+HI1-1:0] ph4_r [3];
  logic signed [JW+HI1-1:0] ph4_nxt [3];
  logic signed [GW-1:0]     g4_r [NUM_VERT][3];
  logic signed [GW-1:0]     g4_nxt [NUM_VERT][3];
  logic signed [DW-1:0]     det5_r, det5_nxt;
  logic signed [2*LO2+1:0]  ll5_r [LANES][3];
  logic signed [2*LO2+1:0]  ll5_nxt [LANES][3];
  logic signed [LO2+HI2:0]  lh5_r [LANES][3];
  logic signed [LO2+HI2:0]  lh5_nxt [LANES][3];
  logic signed [LO2+HI2:0]  hl5_r [LANES][3];
  logic signed [LO2+HI2:0]  hl5_nxt [LANES][3];
  logic signed [2*HI2-1:0]  hh5_r [LANES][3];
  logic signed [2*HI2-1:0]  hh5_nxt [LANES][3];
  logic signed [DW-1:0]     det6_r;
  logic signed [PW-1:0]     pr6_r [LANES][3];
  logic signed [PW-1:0]     pr6_nxt [LANES][3];
  logic signed [DW-1:0]     det7_r;
  logic signed [NW-1:0]     num7_r [LANES];
  logic signed [NW-1:0]     num7_nxt [LANES];

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        jac1_nxt[i][j] = JW'(p_r[j][i]) - JW'(p_r[3][i]);
  end

  always_comb begin
    int r0, r1, c0, c1;
    r0 = 0; r1 = 0; c0 = 0; c1 = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r0 = (i == 0) ? 1 : 0;
        r1 = (i == 2) ? 1 : 2;
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        m2_nxt[i][j][0] = jac1_r[r0][c0] * jac1_r[r1][c1];
        m2_nxt[i][j][1] = jac1_r[r0][c1] * jac1_r[r1][c0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (((i + j) % 2) == 1) cof3_nxt[i][j] = CFW'(m2_r[i][j][1]) - CFW'(m2_r[i][j][0]);
        else                    cof3_nxt[i][j] = CFW'(m2_r[i][j][0]) - CFW'(m2_r[i][j][1]);
  end

  // determinant partial products and shape-function gradients
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pl4_nxt[j] = j0_3_r[j] * $signed({1'b0, cof3_r[0][j][LO1-1:0]});
      ph4_nxt[j] = j0_3_r[j] * $signed(cof3_r[0][j][CFW-1:LO1]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int b = 0; b < 3; b++) g4_nxt[b][i] = GW'(cof3_r[i][b]);
      g4_nxt[3][i] = -(GW'(cof3_r[i][0]) + GW'(cof3_r[i][1]) + GW'(cof3_r[i][2]));
    end
  end

  always_comb begin
    logic signed [GW-1:0] ga, gb;
    ga = '0;
    gb = '0;
    det5_nxt = '0;
    for (int j = 0; j < 3; j++)
      det5_nxt = det5_nxt + (DW'(ph4_r[j]) <<< LO1) + DW'(pl4_r[j]);
    for (int b = 0; b < LANES; b++) begin
      for (int i = 0; i < 3; i++) begin
        ga = g4_r[rowp_r[4]][i];
        gb = g4_r[b][i];
        ll5_nxt[b][i] = $signed({1'b0, ga[LO2-1:0]}) * $signed({1'b0, gb[LO2-1:0]});
        lh5_nxt[b][i] = $signed({1'b0, ga[LO2-1:0]}) * $signed(gb[GW-1:LO2]);
        hl5_nxt[b][i] = $signed(ga[GW-1:LO2]) * $signed({1'b0, gb[LO2-1:0]});
        hh5_nxt[b][i] = $signed(ga[GW-1:LO2]) * $signed(gb[GW-1:LO2]);
      end
    end
  end

  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      for (int i = 0; i < 3; i++)
        pr6_nxt[b][i] = (PW'(hh5_r[b][i]) <<< (2 * LO2))
                      + ((PW'(lh5_r[b][i]) + PW'(hl5_r[b][i])) <<< LO2)
                      + PW'(ll5_r[b][i]);
      num7_nxt[b] = (NW'(pr6_r[b][0]) + NW'(pr6_r[b][1]) + NW'(pr6_r[b][2])) <<< DOT_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:1], issue};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rowp_r[1] <= row_r;
      for (int k = 2; k <= 7; k++) rowp_r[k] <= rowp_r[k-1];
      jac1_r  <= jac1_nxt;
      m2_r    <= m2_nxt;
      for (int j = 0; j < 3; j++) begin
        j0_2_r[j] <= jac1_r[0][j];
        j0_3_r[j] <= j0_2_r[j];
      end
      cof3_r  <= cof3_nxt;
      pl4_r   <= pl4_nxt;
      ph4_r   <= ph4_nxt;
      g4_r    <= g4_nxt;
      det5_r  <= det5_nxt;
      ll5_r   <= ll5_nxt;
      lh5_r   <= lh5_nxt;
      hl5_r   <= hl5_nxt;
      hh5_r   <= hh5_nxt;
      det6_r  <= det5_r;
      pr6_r   <= pr6_nxt;
      det7_r  <= det6_r;
      num7_r  <= num7_nxt;
    end
  end

  // divider: index 0 is sign/abs/overflow set-up, then one quotient bit per stage
  logic [RW:0] dv_r;
  meta_t       dm_r   [RW+1];
  meta_t       dm_nxt [RW+1];
  lane_t       dl_r   [RW+1][LANES];
  lane_t       dl_nxt [RW+1][LANES];

  always_comb begin
    logic signed [DW-1:0]   dsh;
    logic signed [DETX-1:0] dx;
    logic [DW-1:0]          dabs;
    logic [NW-1:0]          nabs;
    logic [DW:0]            t;
    logic [DW:0]            dd;
    logic                   dfit;
    logic                   ge;
    dsh  = det7_r >>> DET_SHIFT;
    dx   = DETX'(dsh);
    dfit = (&dx[DETX-1:RW-1]) || !(|dx[DETX-1:RW-1]);
    dabs = det7_r[DW-1] ? DW'(-det7_r) : DW'(det7_r);
    nabs = '0;
    t    = '0;
    dd   = '0;
    ge   = 1'b0;
    dm_nxt[0].row   = rowp_r[7];
    dm_nxt[0].degen = (det7_r == '0);
    dm_nxt[0].dsat  = !dfit && (det7_r != '0);
    dm_nxt[0].dabs  = dabs;
    if (det7_r == '0) dm_nxt[0].detv = '0;
    else if (dfit)    dm_nxt[0].detv = dx[RW-1:0];
    else              dm_nxt[0].detv = dx[DETX-1] ? KMIN : KMAX;
    for (int l = 0; l < LANES; l++) begin
      nabs = num7_r[l][NW-1] ? NW'(-num7_r[l]) : NW'(num7_r[l]);
      dl_nxt[0][l].neg = num7_r[l][NW-1] ^ det7_r[DW-1];
      dl_nxt[0][l].ov  = CMPW'(nabs) >= (CMPW'(dabs) << RW);
      dl_nxt[0][l].rem = DW'(nabs >> RW);
      dl_nxt[0][l].nlo = nabs[RW-1:0];
      dl_nxt[0][l].q   = '0;
    end
    for (int k = 0; k < RW; k++) begin
      dm_nxt[k+1] = dm_r[k];
      dd = {1'b0, dm_r[k].dabs};
      for (int l = 0; l < LANES; l++) begin
        t  = {dl_r[k][l].rem, dl_r[k][l].nlo[RW-1-k]};
        ge = (t >= dd);
        dl_nxt[k+1][l]     = dl_r[k][l];
        dl_nxt[k+1][l].rem = ge ? DW'(t - dd) : DW'(t);
        dl_nxt[k+1][l].q   = {dl_r[k][l].q[RW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[RW-1:0], vld_r[7]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r <= dm_nxt;
      dl_r <= dl_nxt;
    end
  end

  // saturation to range and output register
  logic [RW-1:0]    kout_r [LANES];
  logic [RW-1:0]    kout_nxt [LANES];
  logic [RW-1:0]    odet_r;
  logic [ROW_W-1:0] orow_r;
  logic             odegen_r;
  logic             osat_r;
  logic             osat_nxt;

  always_comb begin
    lane_t ln;
    ln       = '0;
    osat_nxt = dm_r[RW].dsat;
    for (int l = 0; l < LANES; l++) begin
      ln = dl_r[RW][l];
      if (dm_r[RW].degen) begin
        kout_nxt[l] = '0;
      end else if (ln.ov) begin
        kout_nxt[l] = ln.neg ? KMIN : KMAX;
        osat_nxt    = 1'b1;
      end else if (ln.neg) begin
        if (ln.q > KMIN) begin
          kout_nxt[l] = KMIN;
          osat_nxt    = 1'b1;
        end else begin
          kout_nxt[l] = -ln.q;
        end
      end else if (ln.q[RW-1]) begin
        kout_nxt[l] = KMAX;
        osat_nxt    = 1'b1;
      end else begin
        kout_nxt[l] = ln.q;
      end
    end
    if (dm_r[RW].degen) osat_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kout_r   <= kout_nxt;
      odet_r   <= dm_r[RW].detv;
      orow_r   <= dm_r[RW].row;
      odegen_r <= dm_r[RW].degen;
      osat_r   <= osat_nxt;
    end
  end

  logic [OUTW-1:0] odata;
  always_comb begin
    odata = '0;
    odata[5*RW-1:0] = {odet_r, kout_r[3], kout_r[2], kout_r[1], kout_r[0]};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = odata;
  assign out_tuser  = {osat_r, odegen_r, orow_r};
  assign out_tlast  = (orow_r == ROW_LAST);

  // row counter rests at row 0 while no element is held
  a_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_v_r |-> row_r == ROW_FIRST)
    else $error("row counter not idle without element");

  // a new element only enters when the held one issues its last row
  a_accept_slot: assert property (@(posedge clk) disable iff (!rst_n)
    accept && hold_v_r |-> issue && row_r == ROW_LAST)
    else $error("element overwritten before all rows issued");

  // degenerate rows carry zero entries and no saturation
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && odegen_r |-> odata == '0 && !osat_r)
    else $error("degenerate row with nonzero payload");

endmodule
`default_nettype wire

### verif/tet_element_stiffness_checker.sv
// Checker for tet_element_stiffness_core: predicts the four stiffness rows of every
// accepted element request and compares them with the output requests.
// Depends on tes_pkg.
`timescale 1ns / 1ps
module tet_element_stiffness_checker
  import tes_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [383:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [239:0] out_tdata,
  input  wire logic [USER_W-1:0] out_tuser,
  input  wire logic         out_tlast,
  output int                errors,
  output int                rows_pending
);
  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [239:0]     data;
    logic             degen;
    logic             sat;
    logic             last;
  } stiff_row_t;

  localparam wide_t RES_MAX = (wide_t'(1) <<< 47) - 1;
  localparam wide_t RES_MIN = -(wide_t'(1) <<< 47);

  stiff_row_t rows_q[$];
  int err_cnt = 0;
  int pend_cnt = 0;

  function automatic logic [47:0] clip48(input wide_t v, inout logic sat);
    if (v > RES_MAX) begin
      sat = 1'b1;
      return RES_MAX[47:0];
    end
    if (v < RES_MIN) begin
      sat = 1'b1;
      return RES_MIN[47:0];
    end
    return v[47:0];
  endfunction

  function automatic void predict_rows(input logic [383:0] d);
    wide_t p[4][3];
    wide_t jac[3][3];
    wide_t cof[3][3];
    wide_t grad[4][3];
    wide_t det, dot, m;
    int r0, r1, c0, c1;
    stiff_row_t e;
    logic sat;
    for (int a = 0; a < 4; a++)
      for (int i = 0; i < 3; i++)
        p[a][i] = wide_t'($signed(d[(a*3+i)*32 +: 32]));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        jac[i][j] = p[j][i] - p[3][i];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        r0 = (i == 0) ? 1 : 0;
        r1 = (i == 2) ? 1 : 2;
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        m = jac[r0][c0] * jac[r1][c1] - jac[r0][c1] * jac[r1][c0];
        cof[i][j] = ((i + j) % 2 == 1) ? -m : m;
      end
    det = 0;
    for (int j = 0; j < 3; j++) det = det + jac[0][j] * cof[0][j];
    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 3; a++) grad[a][i] = cof[i][a];
      grad[3][i] = -(cof[i][0] + cof[i][1] + cof[i][2]);
    end
    for (int a = 0; a < 4; a++) begin
      sat = 1'b0;
      e.data = '0;
      e.row = ROW_W'(a);
      e.degen = (det == 0);
      e.last = (a == 3);
      if (det != 0) begin
        for (int b = 0; b < 4; b++) begin
          dot = 0;
          for (int i = 0; i < 3; i++) dot = dot + grad[a][i] * grad[b][i];
          dot = dot <<< DOT_SHIFT;
          e.data[b*48 +: 48] = clip48(dot / det, sat);
        end
        e.data[4*48 +: 48] = clip48(det >>> DET_SHIFT, sat);
      end
      e.sat = sat;
      rows_q.insert(rows_q.size(), e);
    end
  endfunction

  assign errors = err_cnt;
  assign rows_pending = pend_cnt;

  always @(posedge clk) begin
    stiff_row_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_rows(in_tdata);
      if (out_tvalid && out_tready) begin
        if (rows_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected row, got data %h user %h", $time, out_tdata, out_tuser);
        end else begin
          e = rows_q.pop_front();
          for (int b = 0; b < 5; b++)
            if (out_tdata[b*48 +: 48] !== e.data[b*48 +: 48]) begin
              err_cnt++;
              $display("%0t: row %0d word %0d expected %h actual %h", $time, e.row, b,
                       e.data[b*48 +: 48], out_tdata[b*48 +: 48]);
            end
          if (out_tuser[1:0] !== e.row) begin
            err_cnt++;
            $display("%0t: row_index expected %0d actual %0d", $time, e.row, out_tuser[1:0]);
          end
          if (out_tuser[2] !== e.degen) begin
            err_cnt++;
            $display("%0t: row %0d degenerate expected %b actual %b", $time, e.row, e.degen,
                     out_tuser[2]);
          end
          if (out_tuser[3] !== e.sat) begin
            err_cnt++;
            $display("%0t: row %0d saturated expected %b actual %b", $time, e.row, e.sat,
                     out_tuser[3]);
          end
          if (out_tlast !== e.last) begin
            err_cnt++;
            $display("%0t: row %0d tlast expected %b actual %b", $time, e.row, e.last,
                     out_tlast);
          end
        end
      end
    end
    pend_cnt = rows_q.size();
  end
endmodule

### verif/tb_tet_element_stiffness_core.sv
// Testbench top for tet_element_stiffness_core: drives element requests with bursts
// and gaps, stalls the output, and reports the checker's verdict.
// Depends on tes_pkg, tet_element_stiffness_core and tet_element_stiffness_checker.
`timescale 1ns / 1ps
module tb_tet_element_stiffness_core;
  import tes_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [383:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [239:0] out_tdata;
  logic [USER_W-1:0] out_tuser;
  logic out_tlast;
  int errors;
  int rows_pending;
  int burst_left = 0;
  int idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tet_element_stiffness_core i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  tet_element_stiffness_checker i_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .errors, .rows_pending
  );

  // receiver: alternating phases of no stall, light stall and heavy stall
  always @(posedge clk) begin
    int mode;
    mode = int'(($time / 400) % 3);
    if (!rst_n) out_tready <= 1'b0;
    else if (mode == 0) out_tready <= 1'b1;
    else if (mode == 1) out_tready <= ($urandom_range(0, 3) != 0);
    else out_tready <= ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_element(input logic [383:0] d);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  function automatic logic [383:0] pack_tet(input logic signed [31:0] c[12]);
    logic [383:0] d;
    for (int k = 0; k < 12; k++) d[k*32 +: 32] = c[k];
    return d;
  endfunction

  // vertices near a random base point, edge lengths scaled by a random shift
  function automatic logic [383:0] random_tet();
    logic signed [31:0] c[12];
    int sh;
    logic signed [31:0] base[3];
    sh = $urandom_range(4, 30);
    for (int i = 0; i < 3; i++) base[i] = $urandom_range(0, 3) == 0 ? $urandom() : 0;
    for (int k = 0; k < 12; k++)
      c[k] = base[k % 3] + ($signed($urandom()) >>> (31 - sh));
    if ($urandom_range(0, 9) == 0) begin
      // collapse vertex 3 onto the plane of the others
      for (int i = 0; i < 3; i++) c[9+i] = c[i] + c[3+i] - c[6+i];
    end
    return pack_tet(c);
  endfunction

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;

  initial begin
    logic signed [31:0] c[12];
    logic [383:0] d;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    c = '{default: 0};
    send_element(pack_tet(c));                       // all vertices coincide
    c = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0};
    send_element(pack_tet(c));                       // unit tetrahedron
    c = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE, 0, 0, 0};
    send_element(pack_tet(c));                       // inverted
    c = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0};
    send_element(pack_tet(c));                       // det rounds to zero
    c = '{CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX, CMIN, CMIN, CMIN};
    send_element(pack_tet(c));                       // largest spans
    c = '{CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX};
    send_element(pack_tet(c));
    c = '{default: CMAX};
    send_element(pack_tet(c));
    c = '{default: CMIN};
    send_element(pack_tet(c));
    c = '{ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE, 3*ONE, 0, 0, 0};
    send_element(pack_tet(c));                       // collinear
    c = '{-1, 0, 0, 0, -1, 0, 0, 0, -1, 0, 0, 0};
    send_element(pack_tet(c));
    c = '{CMAX, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0};
    send_element(pack_tet(c));                       // sliver
    for (int n = 0; n < 4; n++) begin
      for (int k = 0; k < 12; k++) d[k*32 +: 32] = $urandom();
      send_element(d);
    end

    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);

    for (int n = 0; n < 150; n++) begin
      if ($urandom_range(0, 4) == 0)
        for (int k = 0; k < 12; k++) d[k*32 +: 32] = $urandom();
      else d = random_tet();
      send_element(d);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (rows_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
